FILE: design/lcfb_pkg.sv
// Shared types and constants for the length/checksum frame builder.
package lcfb_pkg;

  localparam int unsigned GROUP_MAX = 6;
  localparam int unsigned GROUP_CW  = $clog2(GROUP_MAX + 1);

  localparam logic [15:0] LEN_OVERHEAD  = 16'd6;
  localparam logic [7:0]  ID_HIGH_RESET = 8'h00;
  localparam logic [7:0]  ID_LOW_RESET  = 8'h16;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic CFG_ID_HIGH = 1'b0;
  localparam logic CFG_ID_LOW  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [15:0] payload_count;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
  } out_word_t;

  // Bytes produced by one input word, first byte in slot 0.
  typedef struct packed {
    logic [GROUP_MAX-1:0][7:0] bytes;
    logic [GROUP_CW-1:0]       count;
    logic                      ends;
  } group_t;

endpackage

FILE: design/lcfb_framer.sv
// Frame state and the byte group produced by each accepted input word.
module lcfb_framer (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  lcfb_pkg::in_word_t word,
  input  logic [7:0]        id_high,
  input  logic [7:0]        id_low,
  output lcfb_pkg::group_t  group
);

  logic        frame_open;
  logic        frame_open_next;
  logic [15:0] bytes_remaining;
  logic [15:0] bytes_remaining_next;
  logic [15:0] running_sum;
  logic [15:0] running_sum_next;

  logic [15:0] len;
  logic [15:0] start_sum;
  logic [15:0] data_sum;
  logic [15:0] rem_dec;

  assign len       = word.payload_count + lcfb_pkg::LEN_OVERHEAD;
  assign start_sum = {8'd0, id_high} + {8'd0, id_low} + {8'd0, len[15:8]} + {8'd0, len[7:0]};
  assign data_sum  = running_sum + {8'd0, word.data_byte};
  assign rem_dec   = bytes_remaining - 16'd1;

  always_comb begin
    frame_open_next      = frame_open;
    bytes_remaining_next = bytes_remaining;
    running_sum_next     = running_sum;
    group                = '0;
    if (word.cmd == lcfb_pkg::CMD_START) begin
      running_sum_next = start_sum;
      group.bytes[0]   = id_high;
      group.bytes[1]   = id_low;
      group.bytes[2]   = len[15:8];
      group.bytes[3]   = len[7:0];
      if (word.payload_count == 16'd0) begin
        group.bytes[4]       = start_sum[15:8];
        group.bytes[5]       = start_sum[7:0];
        group.count          = lcfb_pkg::GROUP_CW'(6);
        group.ends           = 1'b1;
        frame_open_next      = 1'b0;
        bytes_remaining_next = 16'd0;
      end else begin
        group.count          = lcfb_pkg::GROUP_CW'(4);
        frame_open_next      = 1'b1;
        bytes_remaining_next = word.payload_count;
      end
    end else if (frame_open) begin
      running_sum_next = data_sum;
      group.bytes[0]   = word.data_byte;
      if (rem_dec == 16'd0) begin
        group.bytes[1]       = data_sum[15:8];
        group.bytes[2]       = data_sum[7:0];
        group.count          = lcfb_pkg::GROUP_CW'(3);
        group.ends           = 1'b1;
        frame_open_next      = 1'b0;
        bytes_remaining_next = 16'd0;
      end else begin
        group.count          = lcfb_pkg::GROUP_CW'(1);
        bytes_remaining_next = rem_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open      <= 1'b0;
      bytes_remaining <= 16'd0;
      running_sum     <= 16'd0;
    end else if (accept) begin
      frame_open      <= frame_open_next;
      bytes_remaining <= bytes_remaining_next;
      running_sum     <= running_sum_next;
    end
  end

  a_closed_empty: assert property (@(posedge clk) disable iff (rst)
    !frame_open |-> bytes_remaining == 16'd0)
    else $error("closed frame with bytes outstanding");

  a_open_nonzero: assert property (@(posedge clk) disable iff (rst)
    frame_open |-> bytes_remaining != 16'd0)
    else $error("open frame with no bytes outstanding");

  a_group_end: assert property (@(posedge clk) disable iff (rst)
    (accept && group.ends) |=> !frame_open)
    else $error("frame still open after checksum");

endmodule

FILE: design/length_checksum_frame_builder.sv
// Length-prefixed frame builder with 16-bit additive checksum, top level.
// Each input word is turned into its output bytes in the cycle it is accepted and
// loaded into a six-byte output group that drains one byte per cycle while
// out_stall is low. A payload word inside a frame gives one byte, so payload
// streams at one word per cycle while out_stall is low; a start word gives 4
// bytes (6 for an empty frame) and the last payload word 3, and the input stalls
// until the group is down to its final byte being taken. Payload words with no
// frame open are accepted and dropped. Configuration writes are always ready and
// take effect on the next start word.
module length_checksum_frame_builder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lcfb_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lcfb_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data
);

  logic [7:0] id_high;
  logic [7:0] id_low;

  lcfb_pkg::group_t new_group;
  logic [lcfb_pkg::GROUP_MAX-1:0][7:0] bytes;
  logic [lcfb_pkg::GROUP_CW-1:0]       remaining;
  logic                                ends;

  logic in_accept;
  logic out_accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_high <= lcfb_pkg::ID_HIGH_RESET;
      id_low  <= lcfb_pkg::ID_LOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lcfb_pkg::CFG_ID_HIGH: id_high <= cfg_data;
        lcfb_pkg::CFG_ID_LOW:  id_low  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_valid  = remaining != '0;
  assign out_accept = out_valid && !out_stall;
  assign in_stall   = (remaining > lcfb_pkg::GROUP_CW'(1)) ||
                      (remaining == lcfb_pkg::GROUP_CW'(1) && out_stall);
  assign in_accept  = in_valid && !in_stall;

  assign out_data.out_byte  = bytes[0];
  assign out_data.frame_end = ends && (remaining == lcfb_pkg::GROUP_CW'(1));

  lcfb_framer u_framer (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .word    (in_data),
    .id_high (id_high),
    .id_low  (id_low),
    .group   (new_group)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
    end else if (in_accept) begin
      remaining <= new_group.count;
    end else if (out_accept) begin
      remaining <= remaining - lcfb_pkg::GROUP_CW'(1);
    end
  end

  // payload side: shift the group down as bytes leave
  always_ff @(posedge clk) begin
    if (in_accept) begin
      bytes <= new_group.bytes;
      ends  <= new_group.ends;
    end else if (out_accept) begin
      for (int i = 0; i < lcfb_pkg::GROUP_MAX - 1; i++) begin
        bytes[i] <= bytes[i+1];
      end
    end
  end

  a_accept_drained: assert property (@(posedge clk) disable iff (rst)
    in_accept |-> (remaining == '0 || (remaining == lcfb_pkg::GROUP_CW'(1) && !out_stall)))
    else $error("input taken over undelivered bytes");

  a_group_bound: assert property (@(posedge clk) disable iff (rst)
    remaining <= lcfb_pkg::GROUP_CW'(lcfb_pkg::GROUP_MAX))
    else $error("output group overfull");

  a_drain_empty: assert property (@(posedge clk) disable iff (rst)
    (out_accept && remaining == lcfb_pkg::GROUP_CW'(1) && !in_accept) |=> !out_valid)
    else $error("bytes left after final byte taken");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the length/checksum frame builder.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PRINT_LIMIT    = 40;
  localparam int PRESSURE_BYTES = 270;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  lcfb_pkg::in_word_t   in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  lcfb_pkg::out_word_t  out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_index = lcfb_pkg::CFG_ID_HIGH;
  logic [7:0]           cfg_data = '0;

  bit gaps_on  = 1'b1;
  bit stall_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_left = 0;

  int errors = 0;
  int idle_cycles = 0;
  int n_starts = 0, n_abandoned = 0, n_payload = 0, n_dropped = 0;
  int n_checksums = 0, n_cfg = 0, n_out = 0;

  // predicted frame state
  lcfb_pkg::out_word_t pending_bytes[$];
  logic        frame_open = 1'b0;
  logic [15:0] bytes_left = '0;
  logic [15:0] frame_sum = '0;
  logic [7:0]  id_hi = lcfb_pkg::ID_HIGH_RESET;
  logic [7:0]  id_lo = lcfb_pkg::ID_LOW_RESET;

  length_checksum_frame_builder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report(string what);
    errors++;
    if (errors <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $realtime, what);
    end
  endtask

  function automatic void push_byte(logic [7:0] b, logic last);
    lcfb_pkg::out_word_t w;
    w.out_byte  = b;
    w.frame_end = last;
    pending_bytes.push_back(w);
  endfunction

  function automatic void push_checksum();
    push_byte(frame_sum[15:8], 1'b0);
    push_byte(frame_sum[7:0], 1'b1);
    frame_open = 1'b0;
    bytes_left = '0;
    n_checksums++;
  endfunction

  function automatic void build_frame_bytes(lcfb_pkg::in_word_t w);
    logic [15:0] len;
    if (w.cmd == lcfb_pkg::CMD_START) begin
      if (frame_open) n_abandoned++;
      n_starts++;
      len = w.payload_count + lcfb_pkg::LEN_OVERHEAD;
      frame_sum = 16'(id_hi) + 16'(id_lo) + 16'(len[15:8]) + 16'(len[7:0]);
      push_byte(id_hi, 1'b0);
      push_byte(id_lo, 1'b0);
      push_byte(len[15:8], 1'b0);
      push_byte(len[7:0], 1'b0);
      if (w.payload_count == 16'd0) begin
        push_checksum();
      end else begin
        frame_open = 1'b1;
        bytes_left = w.payload_count;
      end
    end else if (frame_open) begin
      n_payload++;
      push_byte(w.data_byte, 1'b0);
      frame_sum  = frame_sum + 16'(w.data_byte);
      bytes_left = bytes_left - 16'd1;
      if (bytes_left == 16'd0) push_checksum();
    end else begin
      n_dropped++;
    end
  endfunction

  // predict on accepted words, then check the accepted output word
  always @(posedge clk) begin : monitor
    lcfb_pkg::out_word_t exp_word;
    bit                  moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lcfb_pkg::CFG_ID_HIGH) id_hi = cfg_data;
        else id_lo = cfg_data;
        n_cfg++;
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        build_frame_bytes(in_data);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        n_out++;
        moved = 1'b1;
        if (pending_bytes.size() == 0) begin
          report($sformatf("unexpected output word %h/%b", out_data.out_byte,
                           out_data.frame_end));
        end else begin
          exp_word = pending_bytes.pop_front();
          if (out_data.out_byte !== exp_word.out_byte) begin
            report($sformatf("out_byte %h, expected %h (output word %0d)",
                             out_data.out_byte, exp_word.out_byte, n_out));
          end
          if (out_data.frame_end !== exp_word.frame_end) begin
            report($sformatf("frame_end %b, expected %b (output word %0d)",
                             out_data.frame_end, exp_word.frame_end, n_out));
          end
        end
      end
    end
    if (rst || moved) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d output words outstanding",
               idle_cycles, pending_bytes.size());
      $display("tb_top failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= stall_on && ($urandom_range(99) < 24);
    end
  end

  task automatic send_word(lcfb_pkg::in_word_t w);
    while (gaps_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_start(logic [15:0] count);
    lcfb_pkg::in_word_t w;
    w.cmd           = lcfb_pkg::CMD_START;
    w.payload_count = count;
    w.data_byte     = 8'($urandom);
    send_word(w);
  endtask

  task automatic send_payload(logic [7:0] b);
    lcfb_pkg::in_word_t w;
    w.cmd           = lcfb_pkg::CMD_PAYLOAD;
    w.payload_count = 16'($urandom);
    w.data_byte     = b;
    send_word(w);
  endtask

  task automatic write_ids(logic [7:0] hi, logic [7:0] lo);
    cfg_valid <= 1'b1;
    cfg_index <= lcfb_pkg::CFG_ID_HIGH;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= lcfb_pkg::CFG_ID_LOW;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // wait until every predicted word has come out, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_orphan_payload();
    send_payload(8'h5A);
    send_start(16'd1);
    send_payload(8'h3C);
    send_payload(8'hC3);
    settle();
  endtask

  task automatic test_reset_ids();
    send_start(16'd0);
    send_start(16'd1);
    send_payload(8'h00);
    settle();
  endtask

  task automatic test_id_extremes();
    write_ids(8'hFF, 8'hFF);
    send_start(16'd2);
    send_payload(8'h00);
    send_payload(8'hFF);
    settle();
    write_ids(8'h00, 8'h00);
    send_start(16'd0);
    settle();
  endtask

  task automatic test_abandon_frame();
    send_start(16'd3);
    send_payload(8'hA5);
    send_start(16'd1);
    send_payload(8'h5A);
    settle();
  endtask

  task automatic test_length_wrap();
    send_start(16'd65529);
    send_payload(8'h01);
    send_start(16'd65530);
    send_payload(8'h02);
    send_start(16'hFFFF);
    send_payload(8'h80);
    send_start(16'd0);
    settle();
  endtask

  // long frame of large bytes behind a receiver hold-off: the checksum wraps
  task automatic test_backpressure();
    write_ids(8'hFF, 8'hFE);
    hold_req = 1'b1;
    send_start(16'(PRESSURE_BYTES));
    for (int i = 0; i < PRESSURE_BYTES; i++) send_payload(8'($urandom_range(250, 255)));
    settle();
  endtask

  task automatic random_frame(inout int sent);
    int r;
    int count;
    int stop;
    r = $urandom_range(99);
    if (r < 8) begin
      send_payload(8'($urandom));
      return;
    end
    if (r < 13) count = $urandom_range(0, 65535);
    else if (r < 30) count = $urandom_range(9, 40);
    else count = $urandom_range(0, 8);
    stop = count;
    if (count > 40) stop = $urandom_range(0, 10);
    else if (count > 0 && $urandom_range(99) < 10) stop = $urandom_range(0, count - 1);
    send_start(16'(count));
    for (int i = 0; i < stop; i++) send_payload(8'($urandom));
    sent += stop + 1;
  endtask

  task automatic test_random_traffic();
    int sent;
    for (int phase = 0; phase < 4; phase++) begin
      write_ids(8'($urandom), 8'($urandom));
      gaps_on  = (phase != 2);
      stall_on = (phase != 2);
      sent = 0;
      while (sent < 50) random_frame(sent);
      settle();
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_orphan_payload();
    test_reset_ids();
    test_id_extremes();
    test_abandon_frame();
    test_length_wrap();
    test_backpressure();
    test_random_traffic();
    $display("Run: %0d starts (%0d abandoned), %0d payload words, %0d dropped words",
             n_starts, n_abandoned, n_payload, n_dropped);
    $display("     %0d checksums, %0d output words checked, %0d id writes, %0d errors",
             n_checksums, n_out, n_cfg, errors);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
